// ----- rtl/est_pkg.sv -----
`default_nettype none
package est_pkg;

	localparam int unsigned PROGRAM_DEPTH = 65536;
	localparam int unsigned POS_W = 17;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [2:0]       opcode;
		logic [POS_W-1:0] position;
		logic [2:0]       error_code;
		logic [1:0]       detected_language;
	} result_t;

	// result kinds
	localparam logic [1:0] KIND_INSTR  = 2'd0;
	localparam logic [1:0] KIND_EXIT   = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;
	localparam logic [1:0] KIND_DETECT = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_SYMBOL = 3'd1;
	localparam logic [2:0] ERR_END    = 3'd2;
	localparam logic [2:0] ERR_LANG   = 3'd3;
	localparam logic [2:0] ERR_LONG   = 3'd4;

	// language modes, also used as detected language codes
	localparam logic [1:0] MODE_OOK    = 2'd0;
	localparam logic [1:0] MODE_COOK   = 2'd1;
	localparam logic [1:0] MODE_BF     = 2'd2;
	localparam logic [1:0] MODE_DETECT = 2'd3;

	// position inside an Ook token
	localparam logic [1:0] LP_START = 2'd0;
	localparam logic [1:0] LP_BIG_O = 2'd1;
	localparam logic [1:0] LP_SMALL = 2'd2;
	localparam logic [1:0] LP_K     = 2'd3;

	// register map
	localparam logic [0:0] REG_LANGUAGE_MODE = 1'd0;

	localparam logic [7:0] CH_BIG_O   = 8'h4F;
	localparam logic [7:0] CH_SMALL_O = 8'h6F;
	localparam logic [7:0] CH_K       = 8'h6B;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_QUEST   = 8'h3F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_LT      = 8'h3C;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;

	localparam logic [1:0] PUNCT_NONE = 2'd3;

	// punctuation index: '.' 0, '!' 1, '?' 2, else none
	function automatic logic [1:0] punct_index(input logic [7:0] ch);
		case (ch)
			CH_DOT:   return 2'd0;
			CH_BANG:  return 2'd1;
			CH_QUEST: return 2'd2;
			default:  return PUNCT_NONE;
		endcase
	endfunction

	// bit 3 set: not a brainfuck symbol
	function automatic logic [3:0] bf_op(input logic [7:0] ch);
		case (ch)
			CH_GT:     return 4'd0;
			CH_LT:     return 4'd1;
			CH_PLUS:   return 4'd2;
			CH_MINUS:  return 4'd3;
			CH_DOT:    return 4'd4;
			CH_COMMA:  return 4'd5;
			CH_LBRACK: return 4'd6;
			CH_RBRACK: return 4'd7;
			default:   return 4'd8;
		endcase
	endfunction

	// opcode for a pair of punctuation marks, bit 3 set when the pair is void
	function automatic logic [3:0] pair_op(input logic [1:0] first, input logic [1:0] second);
		case ({first, second})
			4'b00_00: return 4'd2;
			4'b00_01: return 4'd5;
			4'b00_10: return 4'd0;
			4'b01_00: return 4'd4;
			4'b01_01: return 4'd3;
			4'b01_10: return 4'd6;
			4'b10_00: return 4'd1;
			4'b10_01: return 4'd7;
			default:  return 4'd8;
		endcase
	endfunction

endpackage
`default_nettype wire

// ----- rtl/est_core.sv -----
`default_nettype none
module est_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic            cfg_clear,
	input  wire logic [1:0]      language_mode,
	input  wire est_pkg::item_t  item,
	output logic                 has_result,
	output est_pkg::result_t     result
);
	import est_pkg::*;

	logic [1:0]       token_group_q, token_group_d;
	logic [1:0]       letter_position_q, letter_position_d;
	logic             detect_past_first_q, detect_past_first_d;
	logic             halted_q, halted_d;
	logic [POS_W-1:0] count_q, count_d;

	logic [7:0] ch;
	logic       ws;
	logic [1:0] pidx;
	logic [3:0] bop;
	logic [3:0] pop;
	logic       punct_req, emit_req, fail_req;
	logic [2:0] emit_op;
	logic [2:0] fail_err;

	assign ch   = item.char_code;
	assign ws   = ch <= CH_SPACE;
	assign pidx = punct_index(ch);
	assign bop  = bf_op(ch);
	assign pop  = pair_op(token_group_q - 2'd1, pidx);

	always_comb begin
		token_group_d       = token_group_q;
		letter_position_d   = letter_position_q;
		detect_past_first_d = detect_past_first_q;
		halted_d            = halted_q;
		count_d             = count_q;
		has_result          = 1'b0;
		result              = '0;
		punct_req           = 1'b0;
		emit_req            = 1'b0;
		emit_op             = '0;
		fail_req            = 1'b0;
		fail_err            = ERR_NONE;

		if (item.end_of_text) begin
			if (!halted_q) begin
				has_result      = 1'b1;
				result.position = count_q;
				if (language_mode == MODE_DETECT) begin
					result.result_kind = KIND_ERROR;
					result.error_code  = ERR_LANG;
				end else if (token_group_q == 2'd0 && letter_position_q == LP_START) begin
					result.result_kind = KIND_EXIT;
				end else begin
					result.result_kind = KIND_ERROR;
					result.error_code  = ERR_END;
				end
			end
			token_group_d       = '0;
			letter_position_d   = LP_START;
			detect_past_first_d = 1'b0;
			halted_d            = 1'b0;
			count_d             = '0;
		end else if (!halted_q) begin
			case (language_mode)
				MODE_DETECT: begin
					if (!ws) begin
						if (!detect_past_first_q && ch == CH_BIG_O) begin
							halted_d                 = 1'b1;
							has_result               = 1'b1;
							result.result_kind       = KIND_DETECT;
							result.detected_language = MODE_OOK;
						end else begin
							detect_past_first_d = 1'b1;
							if (ch == CH_DOT) begin
								// undecided, keep looking
							end else if (ch == CH_BANG || ch == CH_QUEST) begin
								halted_d                 = 1'b1;
								has_result               = 1'b1;
								result.result_kind       = KIND_DETECT;
								result.detected_language = MODE_COOK;
							end else if (!bop[3]) begin
								halted_d                 = 1'b1;
								has_result               = 1'b1;
								result.result_kind       = KIND_DETECT;
								result.detected_language = MODE_BF;
							end else begin
								fail_req = 1'b1;
								fail_err = ERR_LANG;
							end
						end
					end
				end
				MODE_BF: begin
					if (!ws) begin
						if (bop[3]) begin
							fail_req = 1'b1;
							fail_err = ERR_SYMBOL;
						end else begin
							emit_req = 1'b1;
							emit_op  = bop[2:0];
						end
					end
				end
				MODE_COOK: begin
					if (!ws)
						punct_req = 1'b1;
				end
				default: begin
					case (letter_position_q)
						LP_START: begin
							if (!ws) begin
								if (ch != CH_BIG_O) begin
									fail_req = 1'b1;
									fail_err = ERR_SYMBOL;
								end else begin
									letter_position_d = LP_BIG_O;
								end
							end
						end
						LP_BIG_O: begin
							if (ch != CH_SMALL_O) begin
								fail_req = 1'b1;
								fail_err = ERR_SYMBOL;
							end else begin
								letter_position_d = LP_SMALL;
							end
						end
						LP_SMALL: begin
							if (ch != CH_K) begin
								fail_req = 1'b1;
								fail_err = ERR_SYMBOL;
							end else begin
								letter_position_d = LP_K;
							end
						end
						default: begin
							letter_position_d = LP_START;
							punct_req         = 1'b1;
						end
					endcase
				end
			endcase

			// first or second half of a punctuation pair
			if (punct_req) begin
				if (pidx == PUNCT_NONE) begin
					fail_req = 1'b1;
					fail_err = ERR_SYMBOL;
				end else if (token_group_q == 2'd0) begin
					token_group_d = pidx + 2'd1;
				end else begin
					token_group_d = '0;
					if (pop[3]) begin
						fail_req = 1'b1;
						fail_err = ERR_SYMBOL;
					end else begin
						emit_req = 1'b1;
						emit_op  = pop[2:0];
					end
				end
			end

			if (emit_req) begin
				if (count_q >= POS_W'(PROGRAM_DEPTH)) begin
					fail_req = 1'b1;
					fail_err = ERR_LONG;
				end else begin
					count_d            = count_q + POS_W'(1);
					has_result         = 1'b1;
					result.result_kind = KIND_INSTR;
					result.opcode      = emit_op;
					result.position    = count_q;
				end
			end

			if (fail_req) begin
				halted_d           = 1'b1;
				has_result         = 1'b1;
				result             = '0;
				result.result_kind = KIND_ERROR;
				result.error_code  = fail_err;
				result.position    = count_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_group_q       <= '0;
			letter_position_q   <= LP_START;
			detect_past_first_q <= 1'b0;
			halted_q            <= 1'b0;
			count_q             <= '0;
		end else if (cfg_clear) begin
			token_group_q       <= '0;
			letter_position_q   <= LP_START;
			detect_past_first_q <= 1'b0;
			halted_q            <= 1'b0;
			count_q             <= '0;
		end else if (step) begin
			token_group_q       <= token_group_d;
			letter_position_q   <= letter_position_d;
			detect_past_first_q <= detect_past_first_d;
			halted_q            <= halted_d;
			count_q             <= count_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/esoteric_source_tokenizer_top.sv -----
`default_nettype none
// channel   | signals                                  | direction
// ----------+------------------------------------------+----------
// item      | item_valid, item_ready, item             | in
// result    | result_valid, result_ready, result       | out
// config    | psel, penable, pwrite, paddr, pwdata,    | in
//           | prdata, pready                           | out
//
// one byte per cycle while result_ready does not stall; an item lands in the input
// register, is decoded from there and its result (if any) sits in the output register
// reset brings language_mode to detect and clears all tokenizer state
// a stalled result only holds the input side when the input register is full
module esoteric_source_tokenizer_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire est_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output est_pkg::result_t      result,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import est_pkg::*;

	logic [1:0] language_mode_q;
	logic       cfg_write;
	logic       item_v_s1;
	item_t      item_s1;
	logic       result_v_q;
	result_t    result_q;
	logic       advance;
	logic       step;
	logic       core_has;
	result_t    core_res;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2:2] == REG_LANGUAGE_MODE);
	assign prdata    = (paddr[2:2] == REG_LANGUAGE_MODE) ? {30'd0, language_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			language_mode_q <= MODE_DETECT;
		else if (cfg_write)
			language_mode_q <= pwdata[1:0];
	end

	assign advance    = !result_v_q || result_ready;
	assign step       = item_v_s1 && advance;
	assign item_ready = !item_v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_v_s1 <= 1'b0;
		else if (item_ready)
			item_v_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	est_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.cfg_clear     (cfg_write),
		.language_mode (language_mode_q),
		.item          (item_s1),
		.has_result    (core_has),
		.result        (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_v_q <= 1'b0;
		else if (advance)
			result_v_q <= step && core_has;
	end

	always_ff @(posedge clk) begin
		if (step && core_has)
			result_q <= core_res;
	end

	assign result_valid = result_v_q;
	assign result       = result_q;

endmodule
`default_nettype wire
